FILE: design/adsr_pkg.sv
// Package for the linear ADSR envelope generator: widths, codes, register
// layout, shared structs and the level saturation helper.
// No dependencies.
package adsr_pkg;

   // Core widths
   localparam int TIME_WIDTH  = 24;
   localparam int LEVEL_WIDTH = 16;

   // Configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = (TIME_WIDTH > LEVEL_WIDTH) ? TIME_WIDTH : LEVEL_WIDTH;

   // Fraction wide enough to hold ONE = 2^LEVEL_WIDTH
   localparam int FRAC_W  = LEVEL_WIDTH + 1;
   localparam int MUL_A_W = (TIME_WIDTH > FRAC_W) ? TIME_WIDTH : FRAC_W;
   localparam int MUL_B_W = FRAC_W;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   localparam logic [FRAC_W-1:0]      LVL_ONE  = {1'b1, {LEVEL_WIDTH{1'b0}}};
   localparam logic [LEVEL_WIDTH-1:0] LVL_MAX  = '1;
   localparam logic [TIME_WIDTH-1:0]  TIME_MAX = '1;

   // Key event codes; the unused code acts as no event
   typedef enum logic [1:0] {
      EV_NONE    = 2'd0,
      EV_PRESS   = 2'd1,
      EV_RELEASE = 2'd2
   } key_event_type;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_ATTACK  = 3'd1,
      PH_DECAY   = 3'd2,
      PH_SUSTAIN = 3'd3,
      PH_RELEASE = 3'd4
   } phase_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_ATTACK_TICKS  = 3'd0,
      REG_ATTACK_STEP   = 3'd1,
      REG_DECAY_TICKS   = 3'd2,
      REG_DECAY_STEP    = 3'd3,
      REG_SUSTAIN_LEVEL = 3'd4,
      REG_RELEASE_TICKS = 3'd5,
      REG_RELEASE_STEP  = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      SEQ_IDLE      = 2'd0,
      SEQ_MUL_PROG  = 2'd1,
      SEQ_MUL_SCALE = 2'd2,
      SEQ_DONE      = 2'd3
   } seq_state_type;

   typedef struct packed {
      logic [TIME_WIDTH-1:0]  attack_ticks;
      logic [LEVEL_WIDTH-1:0] attack_step;
      logic [TIME_WIDTH-1:0]  decay_ticks;
      logic [LEVEL_WIDTH-1:0] decay_step;
      logic [LEVEL_WIDTH-1:0] sustain_level;
      logic [TIME_WIDTH-1:0]  release_ticks;
      logic [LEVEL_WIDTH-1:0] release_step;
   } cfg_type;

   // Request to the shared multiplier
   typedef struct packed {
      logic               en;
      logic [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0] b;
   } mul_req_type;

   // Saturate a value in 0..ONE to the level range
   function automatic logic [LEVEL_WIDTH-1:0] sat_level(logic [FRAC_W-1:0] v);
      return v[LEVEL_WIDTH] ? LVL_MAX : v[LEVEL_WIDTH-1:0];
   endfunction

endpackage

FILE: design/adsr_if.sv
// Channel interfaces of the envelope generator: tick requests, level
// responses and configuration writes. Depends on adsr_pkg.
interface adsr_req_if import adsr_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [1:0] key_event;

   modport source (output valid, output key_event, input ready);
   modport sink   (input valid, input key_event, output ready);
endinterface

interface adsr_rsp_if import adsr_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [LEVEL_WIDTH-1:0] level;
   logic [2:0]             phase;

   modport source (output valid, output level, output phase, input ready);
   modport sink   (input valid, input level, input phase, output ready);
endinterface

interface adsr_csr_if import adsr_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/adsr_csr.sv
// Configuration register file of the envelope generator.
// Depends on adsr_pkg and adsr_csr_if.
module adsr_csr import adsr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   adsr_csr_if.sink   csr_ch,
   output cfg_type    cfg
);

   cfg_type cfg_ff, cfg_in;

   // Writes are always accepted: ready is tied high
   assign csr_ch.ready = 1'b1;
   assign cfg          = cfg_ff;

   // Register decode; upper data bits are dropped, unknown indexes ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            REG_ATTACK_TICKS:  cfg_in.attack_ticks  = csr_ch.data[TIME_WIDTH-1:0];
            REG_ATTACK_STEP:   cfg_in.attack_step   = csr_ch.data[LEVEL_WIDTH-1:0];
            REG_DECAY_TICKS:   cfg_in.decay_ticks   = csr_ch.data[TIME_WIDTH-1:0];
            REG_DECAY_STEP:    cfg_in.decay_step    = csr_ch.data[LEVEL_WIDTH-1:0];
            REG_SUSTAIN_LEVEL: cfg_in.sustain_level = csr_ch.data[LEVEL_WIDTH-1:0];
            REG_RELEASE_TICKS: cfg_in.release_ticks = csr_ch.data[TIME_WIDTH-1:0];
            REG_RELEASE_STEP:  cfg_in.release_step  = csr_ch.data[LEVEL_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.attack_ticks  <= '0;
         cfg_ff.attack_step   <= LVL_MAX;
         cfg_ff.decay_ticks   <= '0;
         cfg_ff.decay_step    <= LVL_MAX;
         cfg_ff.sustain_level <= LVL_MAX;
         cfg_ff.release_ticks <= '0;
         cfg_ff.release_step  <= LVL_MAX;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: design/adsr_mul.sv
// Shared multiplier of the envelope generator, product registered.
// Depends on adsr_pkg.
module adsr_mul import adsr_pkg::*; (
   input  logic                clock,
   input  mul_req_type         mul_req,
   output logic [MUL_P_W-1:0]  product
);

   logic [MUL_P_W-1:0] prod_ff;

   assign product = prod_ff;

   // Product holds while no request is issued
   always_ff @(posedge clock) begin
      if (mul_req.en) begin
         prod_ff <= mul_req.a * mul_req.b;
      end
   end

endmodule

FILE: design/adsr_seq.sv
// Sequencer of the envelope generator: phase and tick counter update, the
// two passes through the shared multiplier, and the response register.
// Depends on adsr_pkg, adsr_req_if and adsr_rsp_if.
module adsr_seq import adsr_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   adsr_req_if.sink            req_ch,
   adsr_rsp_if.source          rsp_ch,
   input  cfg_type             cfg,
   output mul_req_type         mul_req,
   input  logic [MUL_P_W-1:0]  product
);

   seq_state_type          state_ff, state_in;
   phase_type              phase_ff, phase_in;
   logic [TIME_WIDTH-1:0]  elapsed_ff, elapsed_in;
   logic [FRAC_W-1:0]      prog_ff, prog_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_WIDTH-1:0] rsp_level_ff, rsp_level_in;
   phase_type              rsp_phase_ff, rsp_phase_in;

   // Tick update terms
   phase_type              ph_ev, ph_next;
   logic [TIME_WIDTH-1:0]  t_ev, t_inc, dur;
   logic                   timed;
   // Level terms
   logic [LEVEL_WIDTH-1:0] step_sel, lvl;
   logic [FRAC_W-1:0]      prog, scaled;

   assign req_ch.ready = (state_ff == SEQ_IDLE);
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.level = rsp_level_ff;
   assign rsp_ch.phase = rsp_phase_ff;

   // Key event, counter advance and phase timeout
   always_comb begin
      ph_ev = phase_ff;
      t_ev  = elapsed_ff;
      if (req_ch.key_event == EV_PRESS) begin
         ph_ev = PH_ATTACK;
         t_ev  = '0;
      end else if (req_ch.key_event == EV_RELEASE) begin
         ph_ev = PH_RELEASE;
         t_ev  = '0;
      end
      t_inc = (t_ev != TIME_MAX) ? t_ev + TIME_WIDTH'(1) : t_ev;
      dur     = '0;
      ph_next = ph_ev;
      timed   = 1'b1;
      unique case (ph_ev)
         PH_ATTACK: begin
            dur     = cfg.attack_ticks;
            ph_next = PH_DECAY;
         end
         PH_DECAY: begin
            dur     = cfg.decay_ticks;
            ph_next = PH_SUSTAIN;
         end
         PH_RELEASE: begin
            dur     = cfg.release_ticks;
            ph_next = PH_IDLE;
         end
         default: timed = 1'b0;
      endcase
   end

   // Step of the current phase
   always_comb begin
      unique case (phase_ff)
         PH_ATTACK:  step_sel = cfg.attack_step;
         PH_DECAY:   step_sel = cfg.decay_step;
         PH_RELEASE: step_sel = cfg.release_step;
         default:    step_sel = '0;
      endcase
   end

   // Progress clamp and scaled product
   assign prog   = (product > MUL_P_W'(LVL_ONE)) ? LVL_ONE : product[FRAC_W-1:0];
   assign scaled = product[LEVEL_WIDTH +: FRAC_W];

   // Level of the phase: attack from the clamped progress, decay and release from the second product
   always_comb begin
      unique case (phase_ff)
         PH_ATTACK:  lvl = sat_level(prog_ff);
         PH_DECAY:   lvl = sat_level(LVL_ONE - scaled);
         PH_SUSTAIN: lvl = cfg.sustain_level;
         PH_RELEASE: lvl = sat_level(scaled);
         default:    lvl = '0;
      endcase
   end

   // Next state and datapath control
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      elapsed_in   = elapsed_ff;
      prog_in      = prog_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ch.ready;
      rsp_level_in = rsp_level_ff;
      rsp_phase_in = rsp_phase_ff;
      mul_req.en   = 1'b0;
      mul_req.a    = MUL_A_W'(elapsed_ff);
      mul_req.b    = MUL_B_W'(step_sel);
      unique case (state_ff)
         SEQ_IDLE: begin
            if (req_ch.valid) begin
               if (timed && (t_inc > dur)) begin
                  phase_in   = ph_next;
                  elapsed_in = '0;
               end else begin
                  phase_in   = ph_ev;
                  elapsed_in = t_inc;
               end
               state_in = SEQ_MUL_PROG;
            end
         end
         SEQ_MUL_PROG: begin
            // progress = elapsed * step
            mul_req.en = 1'b1;
            state_in   = SEQ_MUL_SCALE;
         end
         SEQ_MUL_SCALE: begin
            // decay scales progress by 1-S, release scales S by 1-progress
            prog_in    = prog;
            mul_req.en = 1'b1;
            if (phase_ff == PH_RELEASE) begin
               mul_req.a = MUL_A_W'(cfg.sustain_level);
               mul_req.b = LVL_ONE - prog;
            end else begin
               mul_req.a = MUL_A_W'(prog);
               mul_req.b = LVL_ONE - FRAC_W'(cfg.sustain_level);
            end
            state_in = SEQ_DONE;
         end
         SEQ_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_level_in = lvl;
               rsp_phase_in = phase_ff;
               state_in     = SEQ_IDLE;
            end
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         phase_ff     <= PH_IDLE;
         elapsed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         elapsed_ff   <= elapsed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      prog_ff      <= prog_in;
      rsp_level_ff <= rsp_level_in;
      rsp_phase_ff <= rsp_phase_in;
   end

endmodule

FILE: design/adsr_envelope_generator.sv
// Top level of the linear ADSR envelope generator.
// Depends on adsr_pkg, the channel interfaces, adsr_csr, adsr_mul, adsr_seq.
//
//   channel   direction  handshake     payload
//   req_ch    in         valid/ready   key_event[1:0]
//   rsp_ch    out        valid/ready   level[15:0], phase[2:0]
//   csr_ch    in         valid/ready   index[2:0], data[23:0]
//
// Each tick runs in four steps: accept with phase/counter update, two passes
// through the one shared multiplier (progress, then scaling), and the load of
// the response register. A new tick is accepted while a response still waits.
// A stalled response holds the sequencer in its last step until taken.
// Reset is synchronous: phase idle, counter zero, registers at defaults;
// no clearing pass. csr writes complete every cycle.
module adsr_envelope_generator import adsr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   adsr_req_if.sink    req_ch,
   adsr_rsp_if.source  rsp_ch,
   adsr_csr_if.sink    csr_ch
);

   cfg_type            cfg;
   mul_req_type        mul_req;
   logic [MUL_P_W-1:0] product;

   adsr_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   adsr_mul u_mul (
      .clock   (clock),
      .mul_req (mul_req),
      .product (product)
   );

   adsr_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .cfg     (cfg),
      .mul_req (mul_req),
      .product (product)
   );

endmodule

FILE: design/adsr_checker.sv
// Port-level checks for the envelope generator, bound to the top level.
// Depends on adsr_pkg and adsr_envelope_generator.
module adsr_checker import adsr_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [LEVEL_WIDTH-1:0] rsp_level,
   input logic [2:0]             rsp_phase
);

   // Reset leaves no response pending
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A pending response stays until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // One tick at a time: busy right after an accept
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // Phase code in range
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_phase <= 3'(PH_RELEASE))
      else $error("phase code out of range");

   // Idle outputs silence
   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_phase == 3'(PH_IDLE) |-> rsp_level == '0)
      else $error("nonzero level in idle");

endmodule

bind adsr_envelope_generator adsr_checker u_adsr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_level (rsp_ch.level),
   .rsp_phase (rsp_ch.phase)
);
